/* design/bis_pkg.sv */
// Shared types, constants and helpers for the bilinear image sampler.
// No dependencies; the other design files except bis_ram use this package.
package bis_pkg;

    localparam int MAX_WIDTH_DEF     = 256;
    localparam int MAX_HEIGHT_DEF    = 256;
    localparam int FRACTION_BITS_DEF = 8;

    localparam int SIZE_W  = 9;   // width/height registers and clamped coordinates
    localparam int COORD_W = 18;  // signed sample position
    localparam int CH_W    = 8;
    localparam int PIX_W   = 3 * CH_W;
    localparam int OUT_W   = 16;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_SAMPLE = 1'b1
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_ADDR,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_RDLAST,
        ST_GO,
        ST_WAIT,
        ST_FIN
    } state_t;

    typedef struct packed {
        cmd_t                      command;
        logic [7:0]                pixel_x;
        logic [7:0]                pixel_y;
        logic [CH_W-1:0]           red_in;
        logic [CH_W-1:0]           green_in;
        logic [CH_W-1:0]           blue_in;
        logic signed [COORD_W-1:0] sample_x;
        logic signed [COORD_W-1:0] sample_y;
    } item_t;

    // four neighbors, red in the top byte of each
    typedef struct packed {
        logic             valid;
        logic [PIX_W-1:0] p00;
        logic [PIX_W-1:0] p10;
        logic [PIX_W-1:0] p01;
        logic [PIX_W-1:0] p11;
    } blend_req_t;

    typedef struct packed {
        logic             valid;
        logic [OUT_W-1:0] red;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] blue;
    } blend_rsp_t;

    // zero reads as one, anything above the maximum saturates
    function automatic logic [SIZE_W-1:0] limit_size(input logic [SIZE_W-1:0] v,
                                                     input int maximum);
        logic [SIZE_W-1:0] r;
        if (v == '0)
            r = SIZE_W'(1);
        else if (int'(v) > maximum)
            r = SIZE_W'(maximum);
        else
            r = v;
        return r;
    endfunction

endpackage

/* design/bis_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bis_ram #(
    parameter int DATA_W = 24,
    parameter int DEPTH  = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/bis_blend.sv */
// Two-stage bilinear blend: horizontal weights, then vertical, per channel.
// Depends on bis_pkg.
module bis_blend #(
    parameter int FRACTION_BITS = bis_pkg::FRACTION_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  bis_pkg::blend_req_t      req,
    input  logic [FRACTION_BITS-1:0] fx,
    input  logic [FRACTION_BITS-1:0] fy,
    output bis_pkg::blend_rsp_t      rsp
);
    import bis_pkg::*;

    localparam int WT_W  = FRACTION_BITS + 1;
    localparam int TOP_W = CH_W + FRACTION_BITS;
    localparam int V_W   = CH_W + 2 * FRACTION_BITS;
    localparam int SHIFT = 2 * FRACTION_BITS - 8;
    localparam logic [WT_W-1:0] ONE = WT_W'(1) << FRACTION_BITS;

    logic [WT_W-1:0]          wx;
    logic [WT_W-1:0]          fx_w;
    logic [WT_W-1:0]          wy_reg;
    logic [WT_W-1:0]          fy_reg;
    logic                     s1_valid_reg;
    logic [TOP_W-1:0]         top_reg [3];
    logic [TOP_W-1:0]         bot_reg [3];
    logic [OUT_W-1:0]         res_reg [3];
    logic                     s2_valid_reg;

    assign fx_w = {1'b0, fx};
    assign wx   = ONE - fx_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= req.valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            fy_reg <= {1'b0, fy};
            wy_reg <= ONE - {1'b0, fy};
        end
    end

    for (genvar ch = 0; ch < 3; ch++)
    begin : g_ch
        localparam int SH = CH_W * (2 - ch);
        logic [TOP_W:0] top_sum;
        logic [TOP_W:0] bot_sum;
        logic [V_W:0]   v_sum;

        always_comb
        begin
            top_sum = (TOP_W+1)'(req.p00[SH +: CH_W]) * (TOP_W+1)'(wx)
                    + (TOP_W+1)'(req.p10[SH +: CH_W]) * (TOP_W+1)'(fx_w);
            bot_sum = (TOP_W+1)'(req.p01[SH +: CH_W]) * (TOP_W+1)'(wx)
                    + (TOP_W+1)'(req.p11[SH +: CH_W]) * (TOP_W+1)'(fx_w);
            v_sum   = (V_W+1)'(top_reg[ch]) * (V_W+1)'(wy_reg)
                    + (V_W+1)'(bot_reg[ch]) * (V_W+1)'(fy_reg);
        end

        always_ff @(posedge clk)
        begin
            if (req.valid)
            begin
                top_reg[ch] <= top_sum[TOP_W-1:0];
                bot_reg[ch] <= bot_sum[TOP_W-1:0];
            end
            if (s1_valid_reg)
            begin
                res_reg[ch] <= OUT_W'(v_sum >> SHIFT);
            end
        end
    end

    assign rsp.valid = s2_valid_reg;
    assign rsp.red   = res_reg[0];
    assign rsp.green = res_reg[1];
    assign rsp.blue  = res_reg[2];

endmodule

/* design/bis_ctrl.sv */
// Sequencer: size registers, write path, neighbor clamping, four pixel reads,
// blend handoff and the output register. Depends on bis_pkg.
module bis_ctrl #(
    parameter int MAX_WIDTH     = bis_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT    = bis_pkg::MAX_HEIGHT_DEF,
    parameter int FRACTION_BITS = bis_pkg::FRACTION_BITS_DEF,
    parameter int ADDR_W        = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [bis_pkg::SIZE_W-1:0]  cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  bis_pkg::item_t              item,
    output logic                        ram_we,
    output logic [ADDR_W-1:0]           ram_addr,
    output logic [bis_pkg::PIX_W-1:0]   ram_wdata,
    input  logic [bis_pkg::PIX_W-1:0]   ram_rdata,
    output bis_pkg::blend_req_t         breq,
    output logic [FRACTION_BITS-1:0]    bfx,
    output logic [FRACTION_BITS-1:0]    bfy,
    input  bis_pkg::blend_rsp_t         brsp,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [bis_pkg::OUT_W-1:0]   out_red,
    output logic [bis_pkg::OUT_W-1:0]   out_green,
    output logic [bis_pkg::OUT_W-1:0]   out_blue,
    output logic                        out_oor
);
    import bis_pkg::*;

    localparam int IC_W   = COORD_W + 1;
    localparam int PROD_W = 2 * SIZE_W;

    state_t            state_reg;
    state_t            state_next;
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    item_t             item_reg;
    logic [SIZE_W-1:0] x0_reg;
    logic [SIZE_W-1:0] x1_reg;
    logic [SIZE_W-1:0] y0_reg;
    logic [SIZE_W-1:0] y1_reg;
    logic [PIX_W-1:0]  pix_reg [4];
    logic              cap_valid_reg;
    logic [1:0]        cap_idx_reg;
    logic [OUT_W-1:0]  res_red_reg;
    logic [OUT_W-1:0]  res_green_reg;
    logic [OUT_W-1:0]  res_blue_reg;
    logic              res_oor_reg;
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_red_reg;
    logic [OUT_W-1:0]  out_green_reg;
    logic [OUT_W-1:0]  out_blue_reg;
    logic              out_oor_reg;

    logic              accept;
    logic              wr_ok;
    logic              rd_issue;
    logic [1:0]        rd_idx;
    logic              out_load;
    logic [SIZE_W-1:0] ax;
    logic [SIZE_W-1:0] ay;
    logic [PROD_W-1:0] addr_full;
    logic signed [IC_W-1:0] ix;
    logic signed [IC_W-1:0] iy;

    function automatic logic [SIZE_W-1:0] clamp_c(input logic signed [IC_W-1:0] c,
                                                  input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] r;
        if (c < 0)
            r = '0;
        else if (c >= $signed({{(IC_W-SIZE_W){1'b0}}, size}))
            r = size - SIZE_W'(1);
        else
            r = c[SIZE_W-1:0];
        return r;
    endfunction

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_load = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);

    assign wr_ok = ({1'b0, item_reg.pixel_x} < width_reg)
                && ({1'b0, item_reg.pixel_y} < height_reg);

    // floor of the signed position is an arithmetic shift
    assign ix = $signed({item_reg.sample_x[COORD_W-1], item_reg.sample_x}) >>> FRACTION_BITS;
    assign iy = $signed({item_reg.sample_y[COORD_W-1], item_reg.sample_y}) >>> FRACTION_BITS;

    // next state and read issue
    always_comb
    begin
        state_next = state_reg;
        rd_issue   = 1'b0;
        rd_idx     = 2'd0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = (item.command == CMD_WRITE) ? ST_WRITE : ST_ADDR;
            end
            ST_WRITE:  state_next = ST_FIN;
            ST_ADDR:   state_next = ST_RD0;
            ST_RD0:
            begin
                rd_issue   = 1'b1;
                rd_idx     = 2'd0;
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                rd_issue   = 1'b1;
                rd_idx     = 2'd1;
                state_next = ST_RD2;
            end
            ST_RD2:
            begin
                rd_issue   = 1'b1;
                rd_idx     = 2'd2;
                state_next = ST_RD3;
            end
            ST_RD3:
            begin
                rd_issue   = 1'b1;
                rd_idx     = 2'd3;
                state_next = ST_RDLAST;
            end
            ST_RDLAST: state_next = ST_GO;
            ST_GO:     state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (brsp.valid)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // one shared address multiplier; read order p00, p10, p01, p11
    always_comb
    begin
        ax = x0_reg;
        ay = y0_reg;
        if (state_reg == ST_WRITE)
        begin
            ax = {1'b0, item_reg.pixel_x};
            ay = {1'b0, item_reg.pixel_y};
        end
        else
        begin
            ax = rd_idx[0] ? x1_reg : x0_reg;
            ay = rd_idx[1] ? y1_reg : y0_reg;
        end
        addr_full = PROD_W'(ay) * PROD_W'(width_reg) + PROD_W'(ax);
    end

    assign ram_addr  = ADDR_W'(addr_full);
    assign ram_we    = (state_reg == ST_WRITE) && wr_ok;
    assign ram_wdata = {item_reg.red_in, item_reg.green_in, item_reg.blue_in};

    assign breq.valid = (state_reg == ST_GO);
    assign breq.p00   = pix_reg[0];
    assign breq.p10   = pix_reg[1];
    assign breq.p01   = pix_reg[2];
    assign breq.p11   = pix_reg[3];
    assign bfx        = item_reg.sample_x[FRACTION_BITS-1:0];
    assign bfy        = item_reg.sample_y[FRACTION_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            width_reg     <= limit_size(SIZE_RESET, MAX_WIDTH);
            height_reg    <= limit_size(SIZE_RESET, MAX_HEIGHT);
            cap_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cap_valid_reg <= rd_issue;
            if (cfg_we)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_WIDTH:  width_reg  <= limit_size(cfg_wdata, MAX_WIDTH);
                    REG_HEIGHT: height_reg <= limit_size(cfg_wdata, MAX_HEIGHT);
                    default:    ;
                endcase
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cap_idx_reg <= rd_idx;
        if (accept)
            item_reg <= item;
        if (state_reg == ST_ADDR)
        begin
            x0_reg <= clamp_c(ix, width_reg);
            x1_reg <= clamp_c(ix + IC_W'(1), width_reg);
            y0_reg <= clamp_c(iy, height_reg);
            y1_reg <= clamp_c(iy + IC_W'(1), height_reg);
        end
        if (cap_valid_reg)
            pix_reg[cap_idx_reg] <= ram_rdata;
        if (state_reg == ST_WRITE)
        begin
            res_red_reg   <= '0;
            res_green_reg <= '0;
            res_blue_reg  <= '0;
            res_oor_reg   <= !wr_ok;
        end
        else if (state_reg == ST_WAIT && brsp.valid)
        begin
            res_red_reg   <= brsp.red;
            res_green_reg <= brsp.green;
            res_blue_reg  <= brsp.blue;
            res_oor_reg   <= 1'b0;
        end
        if (out_load)
        begin
            out_red_reg   <= res_red_reg;
            out_green_reg <= res_green_reg;
            out_blue_reg  <= res_blue_reg;
            out_oor_reg   <= res_oor_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red   = out_red_reg;
    assign out_green = out_green_reg;
    assign out_blue  = out_blue_reg;
    assign out_oor   = out_oor_reg;

    a_rsp_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        brsp.valid |-> state_reg == ST_WAIT)
        else $error("blend result outside wait state");

    a_coords_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD0) |-> (x0_reg < width_reg && x1_reg < width_reg
                                   && y0_reg < height_reg && y1_reg < height_reg))
        else $error("neighbor coordinate outside image");

    a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.command == CMD_SAMPLE) |=> state_reg == ST_ADDR)
        else $error("sample transfer did not start address phase");

    a_write_only_idle_done: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> state_reg == ST_FIN && !res_oor_reg)
        else $error("pixel write without matching result");

endmodule

/* design/bilinear_image_sampler_unit.sv */
// Bilinear image sampler top level: stream ports, pixel RAM, sequencer, blend.
// Depends on bis_pkg, bis_ram, bis_ctrl and bis_blend.
//
// Each input transfer either stores one RGB pixel or samples the image with
// clamp-to-edge bilinear filtering; every input transfer yields exactly one
// output transfer. A sample is paced by the single read port of the pixel
// RAM, which fetches the four neighbors one per cycle, followed by the
// two-stage blend. One item is in flight at a time; the next is accepted
// while the previous result still waits in the output register. Writes
// outside the configured size are dropped and flagged in m_tuser. Pixels
// must be written before they are sampled; the RAM is not cleared at
// reset. Change the size registers only while the block is idle.
module bilinear_image_sampler_unit #(
    parameter int MAX_WIDTH     = bis_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT    = bis_pkg::MAX_HEIGHT_DEF,
    parameter int FRACTION_BITS = bis_pkg::FRACTION_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [bis_pkg::SIZE_W-1:0] cfg_wdata,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // pixel_x, pixel_y, red_in, green_in, blue_in, sample_x, sample_y, 4 pad bits
    input  logic [79:0]                s_tdata,
    // command
    input  logic                       s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // red_out, green_out, blue_out
    output logic [47:0]                m_tdata,
    // write_out_of_range
    output logic                       m_tuser
);
    import bis_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    item_t             item;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [PIX_W-1:0]  ram_wdata;
    logic [PIX_W-1:0]  ram_rdata;
    blend_req_t        breq;
    blend_rsp_t        brsp;
    logic [FRACTION_BITS-1:0] bfx;
    logic [FRACTION_BITS-1:0] bfy;
    logic [OUT_W-1:0]  red;
    logic [OUT_W-1:0]  green;
    logic [OUT_W-1:0]  blue;

    assign item.command  = cmd_t'(s_tuser);
    assign item.pixel_x  = s_tdata[7:0];
    assign item.pixel_y  = s_tdata[15:8];
    assign item.red_in   = s_tdata[23:16];
    assign item.green_in = s_tdata[31:24];
    assign item.blue_in  = s_tdata[39:32];
    assign item.sample_x = s_tdata[57:40];
    assign item.sample_y = s_tdata[75:58];

    bis_ram #(
        .DATA_W (PIX_W),
        .DEPTH  (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    bis_ctrl #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .FRACTION_BITS (FRACTION_BITS),
        .ADDR_W        (ADDR_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .item      (item),
        .ram_we    (ram_we),
        .ram_addr  (ram_addr),
        .ram_wdata (ram_wdata),
        .ram_rdata (ram_rdata),
        .breq      (breq),
        .bfx       (bfx),
        .bfy       (bfy),
        .brsp      (brsp),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_red   (red),
        .out_green (green),
        .out_blue  (blue),
        .out_oor   (m_tuser)
    );

    bis_blend #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_blend (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (breq),
        .fx    (bfx),
        .fy    (bfy),
        .rsp   (brsp)
    );

    assign m_tdata = {blue, green, red};

endmodule

/* tb/bis_checker.sv */
// Watches the stream and config ports of the bilinear image sampler.
// Predicts each result from its own copy of the image and sizes and compares it.
// Depends on bis_pkg.
module bis_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [bis_pkg::SIZE_W-1:0] cfg_wdata,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [79:0]                s_tdata,
    input  logic                       s_tuser,
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [47:0]                m_tdata,
    input  logic                       m_tuser,
    output int                         fail_count,
    output int                         pending
);
    import bis_pkg::*;

    localparam int IMG_DEPTH = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
    localparam int FB        = FRACTION_BITS_DEF;
    localparam int ONE       = 1 << FB;

    typedef struct packed {
        logic [OUT_W-1:0] red;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] blue;
        logic             out_of_range;
    } color_result_t;

    logic [PIX_W-1:0] image_mem [IMG_DEPTH];
    int unsigned      cols;
    int unsigned      rows;
    int               errors;
    color_result_t    expected_colors [$];

    function automatic int unsigned clip_size(input logic [SIZE_W-1:0] raw, input int maximum);
        int unsigned r;
        if (raw == '0)
            r = 1;
        else if (int'(raw) > maximum)
            r = maximum;
        else
            r = raw;
        return r;
    endfunction

    function automatic int unsigned clamp_axis(input int c, input int unsigned size);
        int unsigned r;
        if (c < 0)
            r = 0;
        else if (c >= int'(size))
            r = size - 1;
        else
            r = c;
        return r;
    endfunction

    function automatic color_result_t predict_sample(input logic signed [COORD_W-1:0] sx,
                                                     input logic signed [COORD_W-1:0] sy);
        int               ix;
        int               iy;
        int unsigned      fx;
        int unsigned      fy;
        int unsigned      x0;
        int unsigned      x1;
        int unsigned      y0;
        int unsigned      y1;
        logic [PIX_W-1:0] p00;
        logic [PIX_W-1:0] p10;
        logic [PIX_W-1:0] p01;
        logic [PIX_W-1:0] p11;
        int unsigned      upper;
        int unsigned      lower;
        int unsigned      mix;
        int unsigned      sh;
        logic [OUT_W-1:0] chan [3];
        color_result_t    r;
        ix  = int'(sx) >>> FB;
        iy  = int'(sy) >>> FB;
        fx  = sx[FB-1:0];
        fy  = sy[FB-1:0];
        x0  = clamp_axis(ix, cols);
        x1  = clamp_axis(ix + 1, cols);
        y0  = clamp_axis(iy, rows);
        y1  = clamp_axis(iy + 1, rows);
        p00 = image_mem[y0 * cols + x0];
        p10 = image_mem[y0 * cols + x1];
        p01 = image_mem[y1 * cols + x0];
        p11 = image_mem[y1 * cols + x1];
        for (int ch = 0; ch < 3; ch++)
        begin
            sh    = 16 - 8 * ch;
            upper = ((p00 >> sh) & 8'hFF) * (ONE - fx) + ((p10 >> sh) & 8'hFF) * fx;
            lower = ((p01 >> sh) & 8'hFF) * (ONE - fx) + ((p11 >> sh) & 8'hFF) * fx;
            mix   = upper * (ONE - fy) + lower * fy;
            chan[ch] = OUT_W'(mix >> (2 * FB - 8));
        end
        r.red          = chan[0];
        r.green        = chan[1];
        r.blue         = chan[2];
        r.out_of_range = 1'b0;
        return r;
    endfunction

    // writes update the image copy; samples read it
    function automatic color_result_t predict_item(input logic [79:0] data, input logic cmd);
        logic [7:0]    px;
        logic [7:0]    py;
        color_result_t r;
        px = data[7:0];
        py = data[15:8];
        r  = '0;
        if (cmd == CMD_SAMPLE)
            r = predict_sample(data[57:40], data[75:58]);
        else if (px < cols && py < rows)
            // stored with red in the top byte
            image_mem[py * cols + px] = {data[23:16], data[31:24], data[39:32]};
        else
            r.out_of_range = 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (errors < 100)
            $display("MISMATCH at %0t: %s", $time, what);
        errors++;
    endtask

    task automatic check_result();
        color_result_t want;
        if (expected_colors.size() == 0)
        begin
            report_mismatch("result transfer with no item outstanding");
            return;
        end
        want = expected_colors.pop_front();
        if (m_tdata[15:0] !== want.red)
            report_mismatch($sformatf("red_out %0d, expected %0d", m_tdata[15:0], want.red));
        if (m_tdata[31:16] !== want.green)
            report_mismatch($sformatf("green_out %0d, expected %0d", m_tdata[31:16],
                                      want.green));
        if (m_tdata[47:32] !== want.blue)
            report_mismatch($sformatf("blue_out %0d, expected %0d", m_tdata[47:32], want.blue));
        if (m_tuser !== want.out_of_range)
            report_mismatch($sformatf("write_out_of_range %b, expected %b", m_tuser,
                                      want.out_of_range));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols       = SIZE_RESET;
            rows       = SIZE_RESET;
            errors     = 0;
            expected_colors.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_WIDTH)
                    cols = clip_size(cfg_wdata, MAX_WIDTH_DEF);
                else
                    rows = clip_size(cfg_wdata, MAX_HEIGHT_DEF);
            end
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready)
                expected_colors.push_back(predict_item(s_tdata, s_tuser));
            fail_count <= errors;
            pending    <= expected_colors.size();
        end
    end

endmodule

/* tb/tb.sv */
// Top of the bilinear image sampler testbench: clock, reset, stimulus, verdict.
// Depends on bis_pkg, bis_checker and bilinear_image_sampler_unit.
module tb;
    import bis_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int PHASES        = 22;
    localparam int PHASE_ITEMS   = 72;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic              cfg_index = 1'b0;
    logic [SIZE_W-1:0] cfg_wdata = '0;
    logic              s_tvalid  = 1'b0;
    logic [79:0]       s_tdata   = '0;
    logic              s_tuser   = 1'b0;
    logic              m_tready  = 1'b0;
    logic              s_tready;
    logic              m_tvalid;
    logic [47:0]       m_tdata;
    logic              m_tuser;
    int                fail_count;
    int                pending;

    // stimulus-side view of the image, used to keep samples on written pixels and to place writes
    int unsigned cols = 256;
    int unsigned rows = 256;
    bit          written_entry [MAX_WIDTH_DEF * MAX_HEIGHT_DEF];
    int unsigned focus_x0;
    int unsigned focus_x1;
    int unsigned focus_y0;
    int unsigned focus_y1;
    bit          calm = 1'b0;

    always #5 clk = ~clk;

    bilinear_image_sampler_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    bis_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    function automatic bit take_break();
        return !calm && ($urandom_range(0, 99) < 26);
    endfunction

    always @(posedge clk)
        m_tready <= !take_break();

    function automatic int unsigned clamp_to_image(input int c, input int unsigned size);
        int unsigned r;
        if (c < 0)
            r = 0;
        else if (c >= int'(size))
            r = size - 1;
        else
            r = c;
        return r;
    endfunction

    function automatic bit neighbors_written(input logic signed [COORD_W-1:0] sx,
                                             input logic signed [COORD_W-1:0] sy);
        int          ix;
        int          iy;
        int unsigned xa;
        int unsigned xb;
        int unsigned ya;
        int unsigned yb;
        ix = int'(sx) >>> FRACTION_BITS_DEF;
        iy = int'(sy) >>> FRACTION_BITS_DEF;
        xa = clamp_to_image(ix, cols);
        xb = clamp_to_image(ix + 1, cols);
        ya = clamp_to_image(iy, rows);
        yb = clamp_to_image(iy + 1, rows);
        return written_entry[ya * cols + xa] && written_entry[ya * cols + xb] &&
               written_entry[yb * cols + xa] && written_entry[yb * cols + xb];
    endfunction

    function automatic logic [7:0] pick_channel();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            return 8'h00;
        if (roll < 30)
            return 8'hFF;
        return 8'($urandom());
    endfunction

    function automatic logic [COORD_W-1:0] pick_extreme();
        case ($urandom_range(0, 3))
            0: return 18'h20000;
            1: return 18'h1FFFF;
            2: return 18'h00000;
            default: return 18'h3FFFF;
        endcase
    endfunction

    // send_pixel and send_sample fill unused fields with random bits; the block must ignore them
    task automatic send_item(input cmd_t cmd, input logic [7:0] px, input logic [7:0] py,
                             input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy);
        s_tuser  <= cmd;
        s_tdata  <= {4'b0000, sy, sx, b, g, r, py, px};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        if (cmd == CMD_WRITE && px < cols && py < rows)
            written_entry[py * cols + px] = 1'b1;
        if (take_break())
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while (take_break());
        end
    endtask

    task automatic send_pixel(input logic [7:0] px, input logic [7:0] py);
        send_item(CMD_WRITE, px, py, pick_channel(), pick_channel(), pick_channel(),
                  18'($urandom()), 18'($urandom()));
    endtask

    task automatic send_write();
        logic [7:0] px;
        logic [7:0] py;
        int         roll;
        roll = $urandom_range(0, 99);
        px   = 8'($urandom());
        py   = 8'($urandom());
        if (roll < 15 && (cols < 256 || rows < 256))
        begin
            if (cols < 256 && (rows == 256 || $urandom_range(0, 1)))
                px = 8'($urandom_range(cols, 255));
            else
                py = 8'($urandom_range(rows, 255));
        end
        else if (roll < 60)
        begin
            px = 8'($urandom_range(focus_x0, focus_x1));
            py = 8'($urandom_range(focus_y0, focus_y1));
        end
        else
        begin
            if (cols < 256)
                px = 8'($urandom_range(0, cols - 1));
            if (rows < 256)
                py = 8'($urandom_range(0, rows - 1));
        end
        send_pixel(px, py);
    endtask

    // falls back to a write when no legal position turns up
    task automatic send_sample();
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        int                 roll;
        for (int tries = 0; tries < 16; tries++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 55)
            begin
                sx = 18'(($urandom_range(focus_x0, focus_x1) << 8) | $urandom_range(0, 255));
                sy = 18'(($urandom_range(focus_y0, focus_y1) << 8) | $urandom_range(0, 255));
            end
            else if (roll < 75)
            begin
                sx = 18'((int'($urandom_range(0, cols + 5)) - 3) * 256 + $urandom_range(0, 255));
                sy = 18'((int'($urandom_range(0, rows + 5)) - 3) * 256 + $urandom_range(0, 255));
            end
            else if (roll < 90)
            begin
                sx = 18'($urandom());
                sy = 18'($urandom());
            end
            else
            begin
                sx = pick_extreme();
                sy = pick_extreme();
            end
            if (neighbors_written(sx, sy))
            begin
                send_item(CMD_SAMPLE, 8'($urandom()), 8'($urandom()), 8'($urandom()),
                          8'($urandom()), 8'($urandom()), sx, sy);
                return;
            end
        end
        send_write();
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(input cfg_reg_t which, input logic [SIZE_W-1:0] raw);
        int unsigned v;
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_wdata <= raw;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        v = (raw == '0) ? 1 : ((raw > 256) ? 256 : raw);
        if (which == REG_WIDTH)
            cols = v;
        else
            rows = v;
    endtask

    function automatic logic [SIZE_W-1:0] random_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return SIZE_W'($urandom_range(1, 12));
        if (roll < 75)
            return SIZE_W'($urandom_range(13, 256));
        if (roll < 85)
            return '0;
        return SIZE_W'($urandom_range(257, 511));
    endfunction

    function automatic int unsigned place_focus(input int unsigned size, input int unsigned span);
        case ($urandom_range(0, 2))
            0: return 0;
            1: return size - span;
            default: return $urandom_range(0, size - span);
        endcase
    endfunction

    task automatic run_phase(input int p);
        logic [SIZE_W-1:0] fixed_cols [6] = '{9'd0, 9'd511, 9'd1, 9'd256, 9'd2, 9'd3};
        logic [SIZE_W-1:0] fixed_rows [6] = '{9'd0, 9'd1, 9'd300, 9'd2, 9'd256, 9'd2};
        int unsigned       span_x;
        int unsigned       span_y;
        int                remaining;
        wait_drained();
        if (p < 6)
        begin
            write_size(REG_WIDTH, fixed_cols[p]);
            write_size(REG_HEIGHT, fixed_rows[p]);
        end
        else
        begin
            if ($urandom_range(0, 99) < 85)
                write_size(REG_WIDTH, random_size());
            if ($urandom_range(0, 99) < 85)
                write_size(REG_HEIGHT, random_size());
        end
        calm = (p >= 9 && p <= 12);
        span_x   = (cols < 8) ? cols : 8;
        span_y   = (rows < 8) ? rows : 8;
        focus_x0 = place_focus(cols, span_x);
        focus_y0 = place_focus(rows, span_y);
        focus_x1 = focus_x0 + span_x - 1;
        focus_y1 = focus_y0 + span_y - 1;
        // fill a patch row by row so that samples have written neighbors
        for (int y = focus_y0; y <= focus_y1; y++)
            for (int x = focus_x0; x <= focus_x1; x++)
                send_pixel(8'(x), 8'(y));
        remaining = PHASE_ITEMS - span_x * span_y;
        if (remaining < 20)
            remaining = 20;
        repeat (remaining)
        begin
            if ($urandom_range(0, 99) < 45)
                send_write();
            else
                send_sample();
        end
    endtask

    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items on the full 256 x 256 image left by reset
        send_item(CMD_WRITE, 8'd0, 8'd0, 8'hFF, 8'hFF, 8'hFF, '0, '0);
        send_item(CMD_WRITE, 8'd1, 8'd0, 8'h00, 8'h00, 8'h00, '0, '0);
        send_item(CMD_WRITE, 8'd0, 8'd1, 8'h12, 8'h34, 8'h56, '0, '0);
        send_item(CMD_WRITE, 8'd1, 8'd1, 8'hAB, 8'hCD, 8'hEF, '0, '0);
        send_item(CMD_WRITE, 8'd255, 8'd255, 8'hFF, 8'h00, 8'h80, '0, '0);
        send_item(CMD_WRITE, 8'd254, 8'd255, 8'h01, 8'h02, 8'h03, '0, '0);
        send_item(CMD_WRITE, 8'd255, 8'd254, 8'h80, 8'h80, 8'h80, '0, '0);
        send_item(CMD_WRITE, 8'd254, 8'd254, 8'h7F, 8'hFF, 8'h00, '0, '0);
        send_item(CMD_WRITE, 8'd255, 8'd0, 8'hC0, 8'h3F, 8'hFF, '0, '0);
        send_item(CMD_WRITE, 8'd0, 8'd255, 8'h0F, 8'hF0, 8'h55, '0, '0);
        send_item(CMD_SAMPLE, '0, '0, '0, '0, '0, 18'h00000, 18'h00000);
        send_item(CMD_SAMPLE, '0, '0, '0, '0, '0, 18'h00080, 18'h00080);
        send_item(CMD_SAMPLE, '0, '0, '0, '0, '0, 18'h000FF, 18'h000FF);
        send_item(CMD_SAMPLE, '0, '0, '0, '0, '0, 18'h3FFFF, 18'h3FFFF);
        send_item(CMD_SAMPLE, '0, '0, '0, '0, '0, 18'h20000, 18'h20000);
        send_item(CMD_SAMPLE, '0, '0, '0, '0, '0, 18'h1FFFF, 18'h1FFFF);
        send_item(CMD_SAMPLE, '0, '0, '0, '0, '0, 18'h0FE40, 18'h0FEC0);
        send_item(CMD_SAMPLE, '0, '0, '0, '0, '0, 18'h3FF10, 18'h00040);
        send_item(CMD_SAMPLE, '0, '0, '0, '0, '0, 18'h1FFFF, 18'h20000);
        send_item(CMD_SAMPLE, '0, '0, '0, '0, '0, 18'h20000, 18'h1FFFF);

        for (int p = 0; p < PHASES; p++)
            run_phase(p);
        wait_drained();

        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* bilinear_image_sampler_unit.f */
design/bis_pkg.sv
design/bis_ram.sv
design/bis_blend.sv
design/bis_ctrl.sv
design/bilinear_image_sampler_unit.sv
tb/bis_checker.sv
tb/tb.sv
